// ===== rtl/core/cbsn_pkg.sv =====
// Package for the circular Bartlett smoothing and normalization block.
// Holds sizes, field widths, state, command and status types and the window weight function.
// No dependencies.
package cbsn_pkg;

  localparam int BINS   = 180;
  localparam int TAPS   = 23;
  localparam int RING   = 2 * BINS;
  localparam int ADDR_W = $clog2(BINS);
  localparam int RING_W = $clog2(RING);
  localparam int KS_W   = $clog2(2 * RING);
  localparam int TAP_W  = $clog2(TAPS);

  localparam int BIN_W  = 8;
  localparam int FLUX_W = 24;
  localparam int EXP_W  = 20;
  localparam int TOT_W  = 24;
  localparam int BG_W   = 8;
  localparam int OUT_W  = 32;
  localparam int CIDX_W = 4;
  localparam int CDAT_W = 24;

  localparam int C_W    = FLUX_W + TAP_W + $clog2(2 * TAPS);
  localparam int P_W    = C_W + EXP_W;
  localparam int SUM_W  = 60;
  localparam int SCL_W  = TOT_W + 8;
  localparam int XH_W   = SUM_W / 2;
  localparam int PP_W   = XH_W + SCL_W;
  localparam int NUM_W  = SUM_W + OUT_W;
  localparam int STEP_W = $clog2(OUT_W);

  localparam logic [CIDX_W-1:0] REG_TOTAL = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_BG    = CIDX_W'(1);
  localparam logic              OP_LOAD   = 1'b0;
  localparam logic              OP_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_SETUP, ST_TAP, ST_DRAIN, ST_MUL, ST_ACC,
    ST_N_RD, ST_N_MUL, ST_N_P0, ST_N_P1, ST_N_P2, ST_N_DIV, ST_N_WR
  } state_e;

  typedef struct packed {
    logic              load_we;
    logic              rd_acc;
    logic              out_load;
    logic              acc_clr;
    logic              mac_en;
    logic [ADDR_W-1:0] ring_addr;
    logic              ring_sel;
    logic [TAP_W-1:0]  weight;
    logic [ADDR_W-1:0] bin_addr;
    logic              comb_we;
    logic              prod_load;
    logic              prod_src;
    logic              ws_clr;
    logic              ws_add;
    logic              pp_lo_load;
    logic              pp_hi_load;
    logic              num_load;
    logic              div_step;
    logic              res_we;
  } cmd_t;

  typedef struct packed {
    logic ws_zero;
  } status_t;

  // Bartlett weight of tap n.
  function automatic logic [TAP_W-1:0] win_weight(input logic [TAP_W-1:0] n);
    int d;
    int w;
    d = 2 * int'(n) - (TAPS - 1);
    if (d < 0) d = -d;
    w = (TAPS - 1) - d;
    if ((TAPS % 2) != 0) w = w >> 1;
    if (w < 0) w = 0;
    return TAP_W'(w);
  endfunction

endpackage

// ===== rtl/core/cbsn_intf.sv =====
// Channel interfaces of the smoothing block: request, result and register write.
// Depends on cbsn_pkg for field widths.
interface cbsn_req_if import cbsn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [BIN_W-1:0]  bin;
  logic [FLUX_W-1:0] forward_flux;
  logic [FLUX_W-1:0] backward_flux;
  logic [EXP_W-1:0]  exposure_time;
  logic              last;
  modport source (output valid, operation, bin, forward_flux, backward_flux,
                  exposure_time, last, input ready);
  modport sink (input valid, operation, bin, forward_flux, backward_flux,
                exposure_time, last, output ready);
endinterface

interface cbsn_rsp_if import cbsn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] expected_count;
  modport source (output valid, expected_count, input ready);
  modport sink (input valid, expected_count, output ready);
endinterface

interface cbsn_cfg_if import cbsn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/cbsn_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module cbsn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/cbsn_ctrl.sv =====
// Sequencer of the smoothing block: handshakes, window walk and division steps.
// Depends on cbsn_pkg.
module cbsn_ctrl import cbsn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_valid_i,
  input  logic    req_op_i,
  input  logic    req_last_i,
  output logic    req_ready_o,
  output logic    rsp_valid_o,
  input  logic    rsp_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] b_q, b_d;
  logic [TAP_W-1:0]  j_q, j_d;
  logic              half_q, half_d;
  logic [RING_W-1:0] k_q, k_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              rd_pend_q, out_valid_q;
  logic              acc_load, acc_read;
  logic              last_tap, last_bin;

  function automatic logic [RING_W-1:0] kstart(input logic [ADDR_W-1:0] b,
                                               input logic h);
    logic [KS_W-1:0] s;
    s = KS_W'(b) + (h ? KS_W'(BINS) : '0) + KS_W'(RING - TAPS / 2);
    if (s >= KS_W'(RING)) s = s - KS_W'(RING);
    return s[RING_W-1:0];
  endfunction

  assign req_ready_o = (state_q == ST_IDLE) && !rd_pend_q &&
                       (!out_valid_q || rsp_ready_i);
  assign rsp_valid_o = out_valid_q;
  assign acc_load    = req_valid_i && req_ready_o && (req_op_i == OP_LOAD);
  assign acc_read    = req_valid_i && req_ready_o && (req_op_i == OP_READ);
  assign last_tap    = (j_q == TAP_W'(TAPS - 1));
  assign last_bin    = (b_q == ADDR_W'(BINS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (acc_load && req_last_i) state_d = ST_INIT;
      ST_INIT:  state_d = ST_SETUP;
      ST_SETUP: state_d = ST_TAP;
      ST_TAP:   if (last_tap && half_q) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ACC;
      ST_ACC:   state_d = last_bin ? ST_N_RD : ST_SETUP;
      ST_N_RD:  state_d = status_i.ws_zero ? ST_N_WR : ST_N_MUL;
      ST_N_MUL: state_d = ST_N_P0;
      ST_N_P0:  state_d = ST_N_P1;
      ST_N_P1:  state_d = ST_N_P2;
      ST_N_P2:  state_d = ST_N_DIV;
      ST_N_DIV: if (step_q == STEP_W'(OUT_W - 1)) state_d = ST_N_WR;
      ST_N_WR:  state_d = last_bin ? ST_IDLE : ST_N_RD;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    b_d    = b_q;
    j_d    = j_q;
    half_d = half_q;
    k_d    = k_q;
    step_d = step_q;
    unique case (state_q)
      ST_INIT: b_d = '0;
      ST_SETUP: begin
        j_d    = '0;
        half_d = 1'b0;
        k_d    = kstart(b_q, 1'b0);
      end
      ST_TAP: begin
        if (last_tap) begin
          j_d    = '0;
          half_d = 1'b1;
          k_d    = kstart(b_q, 1'b1);
        end else begin
          j_d = j_q + TAP_W'(1);
          k_d = (k_q == RING_W'(RING - 1)) ? '0 : k_q + RING_W'(1);
        end
      end
      ST_ACC:   b_d = last_bin ? '0 : b_q + ADDR_W'(1);
      ST_N_P2:  step_d = '0;
      ST_N_DIV: step_d = step_q + STEP_W'(1);
      ST_N_WR:  b_d = last_bin ? '0 : b_q + ADDR_W'(1);
      default: ;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_we   = acc_load;
    cmd_o.rd_acc    = acc_read;
    cmd_o.out_load  = rd_pend_q;
    cmd_o.bin_addr  = b_q;
    cmd_o.weight    = win_weight(j_q);
    cmd_o.ring_sel  = (k_q >= RING_W'(BINS));
    cmd_o.ring_addr = cmd_o.ring_sel ? ADDR_W'(k_q - RING_W'(BINS)) : ADDR_W'(k_q);
    unique case (state_q)
      ST_INIT:  cmd_o.ws_clr = 1'b1;
      ST_SETUP: cmd_o.acc_clr = 1'b1;
      ST_TAP:   cmd_o.mac_en = 1'b1;
      ST_MUL: begin
        cmd_o.comb_we   = 1'b1;
        cmd_o.prod_load = 1'b1;
      end
      ST_ACC:   cmd_o.ws_add = 1'b1;
      ST_N_MUL: begin
        cmd_o.prod_load = 1'b1;
        cmd_o.prod_src  = 1'b1;
      end
      ST_N_P0:  cmd_o.pp_lo_load = 1'b1;
      ST_N_P1:  cmd_o.pp_hi_load = 1'b1;
      ST_N_P2:  cmd_o.num_load = 1'b1;
      ST_N_DIV: cmd_o.div_step = 1'b1;
      ST_N_WR:  cmd_o.res_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      b_q         <= '0;
      j_q         <= '0;
      half_q      <= 1'b0;
      k_q         <= '0;
      step_q      <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      b_q       <= b_d;
      j_q       <= j_d;
      half_q    <= half_d;
      k_q       <= k_d;
      step_q    <= step_d;
      rd_pend_q <= acc_read;
      if (rd_pend_q) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == ST_IDLE))
    else $error("request taken outside idle");
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> out_valid_q)
    else $error("read result not presented");
  a_write_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_N_WR) |-> ($past(state_q) == ST_N_DIV || $past(state_q) == ST_N_RD))
    else $error("result written out of sequence");
`endif
endmodule

// ===== rtl/core/cbsn_dp.sv =====
// Datapath of the smoothing block: stores, window MAC, weighted sum, divider.
// Depends on cbsn_pkg and cbsn_ram.
module cbsn_dp import cbsn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [BIN_W-1:0]  bin_i,
  input  logic [FLUX_W-1:0] fwd_i,
  input  logic [FLUX_W-1:0] bwd_i,
  input  logic [EXP_W-1:0]  exp_i,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_idx_i,
  input  logic [CDAT_W-1:0] cfg_data_i,
  output logic [OUT_W-1:0]  count_o
);
  logic [TOT_W-1:0]  total_q;
  logic [BG_W-1:0]   bg_q;
  logic [BINS-1:0]   res_valid_q;
  logic [FLUX_W-1:0] fwd_rd, bwd_rd;
  logic [EXP_W-1:0]  exp_rd;
  logic [C_W-1:0]    comb_rd;
  logic [OUT_W-1:0]  res_rd;
  logic              store_we, in_range;
  logic              mac_q, sel_q;
  logic [TAP_W-1:0]  wgt_q;
  logic [C_W-1:0]    acc_q;
  logic [SUM_W-1:0]  prod_q, ws_q;
  logic [SUM_W:0]    ws_sum;
  logic [PP_W-1:0]   pp_lo_q, pp_hi_q;
  logic [NUM_W-1:0]  num_sum;
  logic [SUM_W-1:0]  rem_q;
  logic [OUT_W-1:0]  qsh_q;
  logic [SUM_W:0]    r2;
  logic              ge;
  logic [SCL_W-1:0]  scale;
  logic [OUT_W:0]    res_sum;
  logic [OUT_W-1:0]  res_val;
  logic [BIN_W-1:0]  rd_bin_q;
  logic [C_W-1:0]    prod_op;

  assign in_range = (bin_i < BIN_W'(BINS));
  assign store_we = cmd_i.load_we && in_range;
  assign status_o.ws_zero = (ws_q == '0);
  assign scale = {total_q, 8'd0};

  cbsn_ram #(.WIDTH(FLUX_W), .DEPTH(BINS)) u_fwd (
    .clk_i, .we_i(store_we), .waddr_i(bin_i[ADDR_W-1:0]), .wdata_i(fwd_i),
    .raddr_i(cmd_i.ring_addr), .rdata_o(fwd_rd));
  cbsn_ram #(.WIDTH(FLUX_W), .DEPTH(BINS)) u_bwd (
    .clk_i, .we_i(store_we), .waddr_i(bin_i[ADDR_W-1:0]), .wdata_i(bwd_i),
    .raddr_i(cmd_i.ring_addr), .rdata_o(bwd_rd));
  cbsn_ram #(.WIDTH(EXP_W), .DEPTH(BINS)) u_exp (
    .clk_i, .we_i(store_we), .waddr_i(bin_i[ADDR_W-1:0]), .wdata_i(exp_i),
    .raddr_i(cmd_i.bin_addr), .rdata_o(exp_rd));
  cbsn_ram #(.WIDTH(C_W), .DEPTH(BINS)) u_comb (
    .clk_i, .we_i(cmd_i.comb_we), .waddr_i(cmd_i.bin_addr), .wdata_i(acc_q),
    .raddr_i(cmd_i.bin_addr), .rdata_o(comb_rd));
  cbsn_ram #(.WIDTH(OUT_W), .DEPTH(BINS)) u_res (
    .clk_i, .we_i(cmd_i.res_we), .waddr_i(cmd_i.bin_addr), .wdata_i(res_val),
    .raddr_i(bin_i[ADDR_W-1:0]), .rdata_o(res_rd));

  assign prod_op = cmd_i.prod_src ? comb_rd : acc_q;
  assign ws_sum  = {1'b0, ws_q} + {1'b0, prod_q};
  assign num_sum = NUM_W'({pp_hi_q, {XH_W{1'b0}}}) + NUM_W'(pp_lo_q);
  assign r2      = {rem_q, qsh_q[OUT_W-1]};
  assign ge      = (r2 >= {1'b0, ws_q});
  assign res_sum = (status_o.ws_zero ? '0 : {1'b0, qsh_q}) + (OUT_W + 1)'({bg_q, 8'd0});
  assign res_val = res_sum[OUT_W] ? '1 : res_sum[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      bg_q        <= BG_W'(10);
      res_valid_q <= '0;
      ws_q        <= '0;
      mac_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_TOTAL: total_q <= cfg_data_i[TOT_W-1:0];
          REG_BG:    bg_q <= cfg_data_i[BG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.res_we) res_valid_q[cmd_i.bin_addr] <= 1'b1;
      if (cmd_i.ws_clr) begin
        ws_q <= '0;
      end else if (cmd_i.ws_add) begin
        ws_q <= ws_sum[SUM_W] ? '1 : ws_sum[SUM_W-1:0];
      end
      mac_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    wgt_q <= cmd_i.weight;
    sel_q <= cmd_i.ring_sel;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (mac_q) begin
      acc_q <= acc_q + C_W'(sel_q ? bwd_rd : fwd_rd) * C_W'(wgt_q);
    end
    if (cmd_i.prod_load) prod_q <= SUM_W'(prod_op) * SUM_W'(exp_rd);
    if (cmd_i.pp_lo_load) pp_lo_q <= PP_W'(prod_q[XH_W-1:0]) * PP_W'(scale);
    if (cmd_i.pp_hi_load) pp_hi_q <= PP_W'(prod_q[SUM_W-1:XH_W]) * PP_W'(scale);
    if (cmd_i.num_load) begin
      rem_q <= num_sum[NUM_W-1:OUT_W];
      qsh_q <= num_sum[OUT_W-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? SUM_W'(r2 - {1'b0, ws_q}) : r2[SUM_W-1:0];
      qsh_q <= {qsh_q[OUT_W-2:0], ge};
    end
    if (cmd_i.rd_acc) rd_bin_q <= bin_i;
    if (cmd_i.out_load) begin
      count_o <= '0;
      if (rd_bin_q < BIN_W'(BINS)) begin
        if (res_valid_q[rd_bin_q[ADDR_W-1:0]]) count_o <= res_rd;
      end
    end
  end
endmodule

// ===== rtl/core/circular_bartlett_smooth_normalize.sv =====
// Top level of the circular Bartlett smoothing and normalization block.
// Depends on cbsn_pkg, the channel interfaces, cbsn_ctrl, cbsn_dp and cbsn_ram.
//
// Load requests store one bin's forward flux, backward flux and exposure. A
// load marked last starts the computation: the 2*BINS fluxes form a ring
// smoothed by a TAPS-tap Bartlett window, one tap per cycle through a single
// multiply-accumulate on the flux store read ports, then each bin's smoothed
// sum times its exposure is added to the weighted sum. A second pass scales
// every bin to the observed event total with two partial products and a
// restoring divider that makes one quotient bit per cycle, adds the background
// and saturates the Q24.8 result. During the computation no request is taken;
// register writes are always taken. A read request returns one bin's count
// from a registered result store read and a registered output, and no new
// request is taken until that count has been handed over. The result store
// reads as zero for every bin until the first computation writes it.
module circular_bartlett_smooth_normalize import cbsn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbsn_req_if.sink     req_i,
  cbsn_rsp_if.source   rsp_o,
  cbsn_cfg_if.sink     cfg_i
);
  cmd_t    cmd;
  status_t status;

  // Register writes are never stalled.
  assign cfg_i.ready = 1'b1;

  cbsn_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_last_i  (req_i.last),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbsn_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .status_o   (status),
    .bin_i      (req_i.bin),
    .fwd_i      (req_i.forward_flux),
    .bwd_i      (req_i.backward_flux),
    .exp_i      (req_i.exposure_time),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .count_o    (rsp_o.expected_count)
  );
endmodule

// ===== bench/tb.sv =====
// Testbench for circular_bartlett_smooth_normalize: loads, computations and reads.
// Depends on cbsn_pkg and the channel interfaces cbsn_req_if, cbsn_rsp_if, cbsn_cfg_if.
// Expected counts come from an in-bench model of the smoothing and scaling.
module tb;
  import cbsn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam logic [63:0] WSUM_MAX  = (64'd1 << 60) - 64'd1;
  // No request is taken while a computation runs.
  localparam int          STALL_LIMIT = 80000;

  typedef struct {
    logic              op;
    logic [BIN_W-1:0]  bin;
    logic [FLUX_W-1:0] fwd;
    logic [FLUX_W-1:0] bwd;
    logic [EXP_W-1:0]  expo;
    logic              last;
  } bin_req_t;

  logic clk_i;
  logic rst_ni;

  cbsn_req_if req_if ();
  cbsn_rsp_if rsp_if ();
  cbsn_cfg_if cfg_if ();

  circular_bartlett_smooth_normalize dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the block: stores, registers and the result table.
  logic [FLUX_W-1:0] fwd_mem [BINS];
  logic [FLUX_W-1:0] bwd_mem [BINS];
  logic [EXP_W-1:0]  expo_mem[BINS];
  logic [OUT_W-1:0]  count_mem[BINS];
  logic [TOT_W-1:0]  total_reg;
  logic [BG_W-1:0]   bg_reg;

  bin_req_t         pending_q[$];
  logic [OUT_W-1:0] count_q[$];
  bin_req_t         cur;
  int               src_idle;
  int               snk_idle;
  int               errors;
  int               issued;
  int               stall_cycles;
  bit               req_taken;
  bit               cfg_taken;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Smooths the flux ring, weights each bin by exposure and rescales every
  // bin to the event total, exactly as the block does after a last load.
  function automatic void smooth_and_scale();
    logic [63:0]  comb[BINS];
    logic [63:0]  acc;
    logic [63:0]  flux;
    logic [63:0]  prod;
    logic [63:0]  wsum;
    logic [127:0] quot;
    logic [63:0]  cnt;
    int           k;
    int           d;
    int           wt;
    for (int i = 0; i < BINS; i++) comb[i] = '0;
    for (int i = 0; i < RING; i++) begin
      acc = '0;
      for (int j = 0; j < TAPS; j++) begin
        k = (i + j + RING - TAPS / 2) % RING;
        flux = (k < BINS) ? 64'(fwd_mem[k]) : 64'(bwd_mem[k - BINS]);
        d = 2 * j - (TAPS - 1);
        if (d < 0) d = -d;
        wt = (TAPS - 1) - d;
        if ((TAPS % 2) != 0) wt = wt / 2;
        if (wt < 0) wt = 0;
        acc += flux * 64'(wt);
      end
      comb[i % BINS] += acc;
    end
    wsum = '0;
    for (int i = 0; i < BINS; i++) begin
      prod = comb[i] * 64'(expo_mem[i]);
      if (prod > WSUM_MAX) prod = WSUM_MAX;
      wsum += prod;
      if (wsum > WSUM_MAX) wsum = WSUM_MAX;
    end
    for (int i = 0; i < BINS; i++) begin
      cnt = 64'(bg_reg) << 8;
      if (wsum != 0) begin
        prod = comb[i] * 64'(expo_mem[i]);
        if (prod > WSUM_MAX) prod = WSUM_MAX;
        quot = (128'(prod) * (128'(total_reg) << 8)) / 128'(wsum);
        if (quot > 128'(COUNT_MAX)) quot = 128'(COUNT_MAX);
        cnt += 64'(quot);
      end
      count_mem[i] = (cnt > 64'(COUNT_MAX)) ? COUNT_MAX : cnt[31:0];
    end
  endfunction

  // Everything seen at the rising edge: accepted requests feed the model,
  // accepted responses are checked, and the watchdog counts idle cycles.
  always @(posedge clk_i) begin
    req_taken = req_if.valid && req_if.ready;
    cfg_taken = cfg_if.valid && cfg_if.ready;
    if (rst_ni) begin
      if (cfg_taken) begin
        if (cfg_if.index == REG_TOTAL) total_reg = cfg_if.data[TOT_W-1:0];
        else if (cfg_if.index == REG_BG) bg_reg = cfg_if.data[BG_W-1:0];
      end
      if (req_taken) begin
        if (req_if.operation == OP_READ) begin
          count_q = {count_q,
                     ((req_if.bin < BINS) ? count_mem[req_if.bin] : OUT_W'(0))};
        end else begin
          // Loads past the last bin are dropped, but a last mark still counts.
          if (req_if.bin < BINS) begin
            fwd_mem[req_if.bin]  = req_if.forward_flux;
            bwd_mem[req_if.bin]  = req_if.backward_flux;
            expo_mem[req_if.bin] = req_if.exposure_time;
          end
          if (req_if.last) smooth_and_scale();
        end
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (count_q.size() == 0) begin
          $error("expected_count: no response expected, actual %h", rsp_if.expected_count);
          errors++;
        end else begin
          if (rsp_if.expected_count !== count_q[0]) begin
            $error("expected_count: expected %h, actual %h", count_q[0],
                   rsp_if.expected_count);
            errors++;
          end
          void'(count_q.pop_front());
        end
      end
      if (req_taken || cfg_taken || (rsp_if.valid && rsp_if.ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Driver and response-side stalls, both changed at the falling edge. A request
  // that is held stays high without being dropped in between.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle);
      if (!req_if.valid || req_taken) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur = pending_q.pop_front();
          req_if.valid         <= 1'b1;
          req_if.operation     <= cur.op;
          req_if.bin           <= cur.bin;
          req_if.forward_flux  <= cur.fwd;
          req_if.backward_flux <= cur.bwd;
          req_if.exposure_time <= cur.expo;
          req_if.last          <= cur.last;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  function automatic void push_load(logic [BIN_W-1:0] bin, logic [FLUX_W-1:0] fwd,
                                    logic [FLUX_W-1:0] bwd, logic [EXP_W-1:0] expo,
                                    logic last);
    bin_req_t it;
    it.op = OP_LOAD; it.bin = bin; it.fwd = fwd; it.bwd = bwd;
    it.expo = expo; it.last = last;
    pending_q = {pending_q, it};
    issued++;
  endfunction

  // Reads carry random filler in the unused fields so every bit toggles.
  function automatic void push_read(logic [BIN_W-1:0] bin);
    bin_req_t it;
    it.op = OP_READ; it.bin = bin; it.fwd = FLUX_W'($urandom);
    it.bwd = FLUX_W'($urandom); it.expo = EXP_W'($urandom); it.last = 1'($urandom);
    pending_q = {pending_q, it};
    issued++;
  endfunction

  function automatic logic [FLUX_W-1:0] pick_flux();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return FLUX_W'($urandom_range(255));
      default: return FLUX_W'($urandom);
    endcase
  endfunction

  function automatic logic [BIN_W-1:0] pick_bin();
    if ($urandom_range(9) == 0) return BIN_W'($urandom_range(BINS, 255));
    return BIN_W'($urandom_range(BINS - 1));
  endfunction

  // The sender holds off until every read has answered; each phase ends
  // with a read, so the block is idle after that.
  task automatic drain();
    wait (pending_q.size() == 0 && !req_if.valid && count_q.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int n;
    rst_ni = 1'b0;
    req_if.valid = 1'b0; req_if.operation = OP_LOAD; req_if.bin = '0;
    req_if.forward_flux = '0; req_if.backward_flux = '0;
    req_if.exposure_time = '0; req_if.last = 1'b0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = REG_TOTAL; cfg_if.data = '0;
    total_reg = '0; bg_reg = BG_W'(10);
    for (int i = 0; i < BINS; i++) count_mem[i] = '0;
    errors = 0; issued = 0; stall_cycles = 0;
    src_idle = 30; snk_idle = 67;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Before any computation every bin reads as zero, in range or not.
    push_read(0); push_read(BINS - 1); push_read(BINS); push_read(255);
    push_load(200, '1, '1, '1, 1'b0);
    // First full set under reset registers: total of zero gives background only.
    for (int i = 0; i < BINS; i++) begin
      if (i == 0) push_load(i, '1, '1, '1, 1'b0);
      else if (i == 1) push_load(i, '0, '0, '0, 1'b0);
      else push_load(i, pick_flux(), pick_flux(), EXP_W'($urandom), i == BINS - 1);
    end
    push_read(0); push_read(1); push_read(BINS - 1); push_read(255);
    drain();

    write_reg(REG_TOTAL, '1);
    write_reg(REG_BG, '0);
    // A last mark on a dropped load still recomputes with the new registers.
    push_load(250, '1, '1, '1, 1'b1);
    push_read(0); push_read(90); push_read(BINS - 1);
    drain();

    // No exposure anywhere: weighted sum is zero, every bin is background.
    write_reg(REG_BG, BG_W'(255));
    for (int i = 0; i < BINS; i++) push_load(i, pick_flux(), pick_flux(), '0, i == BINS - 1);
    push_read(3); push_read(7); push_read(178);
    drain();

    // One exposed bin takes the whole total and saturates with the background.
    push_load(7, '1, '1, '1, 1'b1);
    push_read(7); push_read(8); push_read(200);
    drain();

    // Random sets: a few reloads with a closing last, some reads in between.
    n = 0;
    while (issued < 900) begin
      if (issued < 480) begin
        src_idle = 67; snk_idle = 30;
      end else if (issued < 700) begin
        src_idle = 0; snk_idle = 0;
      end
      if ($urandom_range(2) == 0) write_reg(REG_TOTAL, CDAT_W'($urandom));
      if ($urandom_range(3) == 0) write_reg(REG_BG, CDAT_W'($urandom_range(255)));
      if (n == 4) write_reg(REG_TOTAL, '0);
      if (n == 6) write_reg(REG_BG, CDAT_W'(255));
      for (int i = $urandom_range(1, 30); i > 0; i--) begin
        if ($urandom_range(7) == 0) push_read(pick_bin());
        push_load(pick_bin(), pick_flux(), pick_flux(),
                  ($urandom_range(5) == 0) ? EXP_W'('1) : EXP_W'($urandom), i == 1);
      end
      for (int i = $urandom_range(5, 25); i > 0; i--) push_read(pick_bin());
      drain();
      n++;
    end

    drain();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
